FILE: hw/rtl/cra_pkg.sv
package cra_pkg;

  localparam int unsigned MaxRegions = 32;
  localparam int unsigned IdxW       = $clog2(MaxRegions);
  localparam int unsigned CntW       = $clog2(MaxRegions + 1);
  localparam int unsigned AddrW      = 21;
  localparam logic [AddrW-1:0] MemSize = AddrW'(1048576);

  localparam logic FuncRequest = 1'b0;
  localparam logic FuncRelease = 1'b1;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StBadSize = 2'd1;
  localparam logic [1:0] StNoSpace = 2'd2;
  localparam logic [1:0] StFull    = 2'd3;

  typedef struct packed {
    logic [AddrW-1:0] start_addr;
    logic [AddrW-1:0] end_addr;
    logic [7:0]       owner;
  } region_t;

endpackage

FILE: hw/rtl/contiguous_region_allocator_top.sv
// Contiguous region allocator, first fit or best fit, over a 1M-unit space.
// Command channel: drive func_i, owner_id_i, req_size_i and fit_mode_i with
// start_i high; the command is taken at a clock edge where busy_o is low.
// busy_o stays high until the reply. The reply (status_o, start_addr_o,
// end_addr_o) is shown for one cycle with done_o high; it cannot be held off.
// The region table lives in one RAM with a registered read port; a single
// sequencer reads, then evaluates, one entry at a time with one shared subtract/compare.
// Request: size and fullness checks, then a scan of up to N+1 holes (N
// regions in use), a read and an evaluate step per entry, then a shift of
// the table upward from the insertion point, a read and a write per moved
// entry, then the write of the new entry.
// Release: one compacting read/write pass over the table.
// Bad-size and table-full replies follow the checks directly. The next
// command may start in the cycle after done_o.
// Reset empties the table (region count to zero); no RAM clearing is done,
// so commands are accepted right after reset.
module contiguous_region_allocator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        func_i,
  input  logic [7:0]  owner_id_i,
  input  logic [20:0] req_size_i,
  input  logic        fit_mode_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [19:0] start_addr_o,
  output logic [20:0] end_addr_o
);

  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SCheck  = 4'd1;
  localparam logic [3:0] SScanRd = 4'd2;
  localparam logic [3:0] SScanEv = 4'd3;
  localparam logic [3:0] SShRd   = 4'd4;
  localparam logic [3:0] SShWr   = 4'd5;
  localparam logic [3:0] SIns    = 4'd6;
  localparam logic [3:0] SRelRd  = 4'd7;
  localparam logic [3:0] SRelEv  = 4'd8;
  localparam logic [3:0] SDone   = 4'd9;

  localparam int unsigned IdxW  = cra_pkg::IdxW;
  localparam int unsigned CntW  = cra_pkg::CntW;
  localparam int unsigned AddrW = cra_pkg::AddrW;

  logic [3:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] i_q, i_d;
  logic [CntW-1:0] w_q, w_d;
  logic            func_q;
  logic [7:0]      owner_q;
  logic [AddrW-1:0] size_q;
  logic            best_q;
  logic [AddrW-1:0] prev_end_q, prev_end_d;
  logic            found_q, found_d;
  logic [CntW-1:0] pick_pos_q, pick_pos_d;
  logic [AddrW-1:0] pick_start_q, pick_start_d;
  logic [AddrW-1:0] pick_hole_q, pick_hole_d;
  logic [1:0]      status_q, status_d;
  logic [AddrW-1:0] rs_q, rs_d, re_q, re_d;

  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  cra_pkg::region_t wdata, rdata;

  cra_ram #(.Width($bits(cra_pkg::region_t)), .Depth(cra_pkg::MaxRegions)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // shared hole unit: next bound minus previous end, compared to the size
  logic [AddrW-1:0] next_bound, hole;
  logic             hole_fits;
  always_comb begin
    next_bound = (i_q < count_q) ? rdata.start_addr : cra_pkg::MemSize;
    hole       = (next_bound >= prev_end_q) ? next_bound - prev_end_q : '0;
    hole_fits  = hole >= size_q;
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    i_d          = i_q;
    w_d          = w_q;
    prev_end_d   = prev_end_q;
    found_d      = found_q;
    pick_pos_d   = pick_pos_q;
    pick_start_d = pick_start_q;
    pick_hole_d  = pick_hole_q;
    status_d     = status_q;
    rs_d         = rs_q;
    re_d         = re_q;
    we           = 1'b0;
    waddr        = w_q[IdxW-1:0];
    wdata        = rdata;
    raddr        = i_q[IdxW-1:0];
    unique case (state_q)
      SIdle: begin
        if (start_i) begin
          i_d        = '0;
          w_d        = '0;
          prev_end_d = '0;
          found_d    = 1'b0;
          rs_d       = '0;
          re_d       = '0;
          status_d   = cra_pkg::StOk;
          state_d    = (func_i == cra_pkg::FuncRelease) ? SRelRd : SCheck;
        end
      end
      SCheck: begin
        if (size_q == '0 || size_q > cra_pkg::MemSize) begin
          status_d = cra_pkg::StBadSize;
          state_d  = SDone;
        end else if (count_q >= CntW'(cra_pkg::MaxRegions)) begin
          status_d = cra_pkg::StFull;
          state_d  = SDone;
        end else begin
          state_d = SScanRd;
        end
      end
      SScanRd: state_d = SScanEv;
      SScanEv: begin
        if (hole_fits && (!found_q || (best_q && hole < pick_hole_q))) begin
          found_d      = 1'b1;
          pick_pos_d   = i_q;
          pick_start_d = prev_end_q;
          pick_hole_d  = hole;
        end
        prev_end_d = rdata.end_addr;
        if ((hole_fits && !best_q) || i_q == count_q) begin
          if (hole_fits || found_q) begin
            i_d     = count_q;
            state_d = (count_q == (hole_fits && (!found_q || (best_q && hole < pick_hole_q))
                       ? i_q : pick_pos_q)) ? SIns : SShRd;
            if (hole_fits && (!found_q || (best_q && hole < pick_hole_q))) begin
              pick_pos_d = i_q;
            end
          end else begin
            status_d = cra_pkg::StNoSpace;
            state_d  = SDone;
          end
        end else begin
          i_d     = i_q + 1'b1;
          state_d = SScanRd;
        end
      end
      SShRd: begin
        raddr   = IdxW'(i_q - 1'b1);
        state_d = SShWr;
      end
      SShWr: begin
        we    = 1'b1;
        waddr = i_q[IdxW-1:0];
        i_d   = i_q - 1'b1;
        state_d = (i_q - 1'b1 == pick_pos_q) ? SIns : SShRd;
      end
      SIns: begin
        we               = 1'b1;
        waddr            = pick_pos_q[IdxW-1:0];
        wdata.start_addr = pick_start_q;
        wdata.end_addr   = pick_start_q + size_q;
        wdata.owner      = owner_q;
        count_d          = count_q + 1'b1;
        rs_d             = pick_start_q;
        re_d             = pick_start_q + size_q;
        state_d          = SDone;
      end
      SRelRd: begin
        if (i_q == count_q) begin
          count_d = w_q;
          state_d = SDone;
        end else begin
          state_d = SRelEv;
        end
      end
      SRelEv: begin
        if (rdata.owner != owner_q) begin
          we  = 1'b1;
          w_d = w_q + 1'b1;
        end
        i_d     = i_q + 1'b1;
        state_d = SRelRd;
      end
      SDone: state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && start_i) begin
      func_q  <= func_i;
      owner_q <= owner_id_i;
      size_q  <= req_size_i;
      best_q  <= fit_mode_i;
    end
    i_q          <= i_d;
    w_q          <= w_d;
    prev_end_q   <= prev_end_d;
    found_q      <= found_d;
    pick_pos_q   <= pick_pos_d;
    pick_start_q <= pick_start_d;
    pick_hole_q  <= pick_hole_d;
    status_q     <= status_d;
    rs_q         <= rs_d;
    re_q         <= re_d;
  end

  assign busy_o       = (state_q != SIdle);
  assign done_o       = (state_q == SDone);
  assign status_o     = (func_q == cra_pkg::FuncRelease) ? cra_pkg::StOk : status_q;
  assign start_addr_o = rs_q[19:0];
  assign end_addr_o   = re_q;

endmodule

FILE: hw/rtl/cra_ram.sv
module cra_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: tb/region_checker.sv
module region_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic        func_i,
  input  logic [7:0]  owner_id_i,
  input  logic [20:0] req_size_i,
  input  logic        fit_mode_i,
  input  logic        done_i,
  input  logic [1:0]  status_i,
  input  logic [19:0] start_addr_i,
  input  logic [20:0] end_addr_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  status;
    logic [19:0] start_addr;
    logic [20:0] end_addr;
  } reply_t;

  cra_pkg::region_t table_q[$];
  reply_t  reply_q[$];
  int      fails;

  assign fail_count_o = fails;
  assign pending_o    = reply_q.size();

  function automatic reply_t apply_command(logic func, logic [7:0] owner,
                                           logic [20:0] size, logic best);
    reply_t           rep;
    cra_pkg::region_t tmp[$];
    cra_pkg::region_t reg_n;
    logic [20:0]     prev_end;
    logic [20:0]     nxt;
    logic [20:0]     hole;
    logic [20:0]     pick_start;
    logic [20:0]     pick_hole;
    int              pick_pos;
    bit              found;
    rep = '0;
    if (func == cra_pkg::FuncRelease) begin
      foreach (table_q[i]) if (table_q[i].owner != owner) tmp.push_back(table_q[i]);
      table_q = tmp;
      return rep;
    end
    if (size == 0 || size > cra_pkg::MemSize) begin
      rep.status = cra_pkg::StBadSize;
      return rep;
    end
    if (table_q.size() >= cra_pkg::MaxRegions) begin
      rep.status = cra_pkg::StFull;
      return rep;
    end
    prev_end = '0;
    found = 0;
    pick_pos = 0;
    pick_start = '0;
    pick_hole = '0;
    for (int i = 0; i <= table_q.size(); i++) begin
      nxt  = (i < table_q.size()) ? table_q[i].start_addr : cra_pkg::MemSize;
      hole = (nxt >= prev_end) ? nxt - prev_end : '0;
      if (hole >= size) begin
        if (!found || (best && hole < pick_hole)) begin
          found = 1;
          pick_pos = i;
          pick_start = prev_end;
          pick_hole = hole;
        end
        if (!best) break;
      end
      if (i < table_q.size()) prev_end = table_q[i].end_addr;
    end
    if (!found) begin
      rep.status = cra_pkg::StNoSpace;
      return rep;
    end
    reg_n.start_addr = pick_start;
    reg_n.end_addr   = pick_start + size;
    reg_n.owner      = owner;
    table_q.insert(pick_pos, reg_n);
    rep.status     = cra_pkg::StOk;
    rep.start_addr = pick_start[19:0];
    rep.end_addr   = reg_n.end_addr;
    return rep;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    if (!rst_ni) begin
      table_q.delete();
      reply_q.delete();
      fails <= 0;
    end else begin
      if (start_i && !busy_i)
        reply_q.push_back(apply_command(func_i, owner_id_i, req_size_i, fit_mode_i));
      if (done_i) begin
        if (reply_q.size() == 0) begin
          fails <= fails + 1;
          if (fails < 10) $display("unexpected reply at %0t", $realtime);
        end else begin
          want = reply_q.pop_front();
          if (want.status !== status_i || want.start_addr !== start_addr_i ||
              want.end_addr !== end_addr_i) begin
            fails <= fails + 1;
            if (fails < 10)
              $display("mismatch: exp st=%0d s=%0h e=%0h got st=%0d s=%0h e=%0h",
                       want.status, want.start_addr, want.end_addr,
                       status_i, start_addr_i, end_addr_i);
          end
        end
      end
    end
  end
endmodule

FILE: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk, rst_n, start, busy, func, fit_mode, done;
  logic [7:0]  owner_id;
  logic [20:0] req_size;
  logic [1:0]  status;
  logic [19:0] start_addr;
  logic [20:0] end_addr;
  int          fail_count, pending;

  contiguous_region_allocator_top dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy), .func_i(func),
    .owner_id_i(owner_id), .req_size_i(req_size), .fit_mode_i(fit_mode),
    .done_o(done), .status_o(status), .start_addr_o(start_addr), .end_addr_o(end_addr)
  );

  region_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_i(busy), .func_i(func),
    .owner_id_i(owner_id), .req_size_i(req_size), .fit_mode_i(fit_mode),
    .done_i(done), .status_i(status), .start_addr_i(start_addr),
    .end_addr_i(end_addr), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // One transaction: hold start until taken; start stays high into the next
  // transaction unless the sender idles first.
  task automatic send_cmd(logic f, logic [7:0] id, logic [20:0] sz, logic m, bit calm);
    if (!calm && $urandom_range(99) < 13) begin
      start <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    start <= 1;
    func <= f;
    owner_id <= id;
    req_size <= sz;
    fit_mode <= m;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  function automatic logic [20:0] rand_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return 21'($urandom_range(1, 4096));
    if (r < 80) return 21'($urandom_range(1, 131072));
    if (r < 90) return 21'($urandom_range(1, 1048576));
    if (r < 95) return 21'($urandom_range(0, 2097151));
    return 21'($urandom_range(0, 1) ? 0 : 1048576);
  endfunction

  initial begin
    bit calm;
    start = 0; func = 0; owner_id = 0; req_size = 0; fit_mode = 0;
    rst_n = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    // directed: size limits, both fits, holes at zero and at the top, full table
    send_cmd(cra_pkg::FuncRequest, 8'd1, 21'd0, 1'b0, 1);
    send_cmd(cra_pkg::FuncRequest, 8'd1, 21'd1048577, 1'b0, 1);
    send_cmd(cra_pkg::FuncRequest, 8'd1, 21'h1FFFFF, 1'b1, 1);
    send_cmd(cra_pkg::FuncRequest, 8'd255, 21'd1048576, 1'b0, 1);
    send_cmd(cra_pkg::FuncRequest, 8'd0, 21'd1, 1'b1, 1);
    send_cmd(cra_pkg::FuncRelease, 8'd255, 21'h1FFFFF, 1'b1, 1);
    send_cmd(cra_pkg::FuncRequest, 8'd2, 21'd100, 1'b0, 1);
    send_cmd(cra_pkg::FuncRequest, 8'd3, 21'd50, 1'b0, 1);
    send_cmd(cra_pkg::FuncRequest, 8'd2, 21'd200, 1'b0, 1);
    send_cmd(cra_pkg::FuncRelease, 8'd2, 21'd0, 1'b0, 1);
    send_cmd(cra_pkg::FuncRequest, 8'd4, 21'd150, 1'b1, 1);
    send_cmd(cra_pkg::FuncRequest, 8'd5, 21'd80, 1'b0, 1);
    send_cmd(cra_pkg::FuncRelease, 8'd7, 21'd0, 1'b0, 1);
    send_cmd(cra_pkg::FuncRelease, 8'd0, 21'd0, 1'b0, 1);
    for (int i = 0; i < 33; i++) send_cmd(cra_pkg::FuncRequest, 8'(i), 21'd16, i[0], 1);
    send_cmd(cra_pkg::FuncRequest, 8'd9, 21'd0, 1'b0, 1);
    for (int i = 0; i < 33; i++) send_cmd(cra_pkg::FuncRelease, 8'(i), 21'd0, 1'b0, 1);
    for (int n = 0; n < 1400; n++) begin
      calm = (n >= 500 && n < 700);
      if ($urandom_range(99) < 22)
        send_cmd(cra_pkg::FuncRelease, 8'($urandom_range(0, 15) == 0 ? $urandom_range(0, 255)
                 : $urandom_range(0, 15)), 21'($urandom), 1'($urandom), calm);
      else
        send_cmd(cra_pkg::FuncRequest, 8'($urandom_range(0, 7) == 0 ? $urandom_range(0, 255)
                 : $urandom_range(0, 15)), rand_size(), 1'($urandom), calm);
    end
    start <= 0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #10ms;
    $display("FAILURE");
    $finish;
  end
endmodule
